// ===== rtl/core/indexed_insert_delete_list_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the indexed insert/delete list unit
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_DELETE_LIST_UNIT_DEFINES_SVH
`define INDEXED_INSERT_DELETE_LIST_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define IIDL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iidl assertion failed");

// next-cycle implication, disabled in reset
`define IIDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iidl assertion failed");

`endif

// ===== rtl/core/iidl_pkg.sv =====
// ----------------------------------------------------------------------------
// iidl_pkg
// Types and constants for the indexed insert/delete list unit.
// ----------------------------------------------------------------------------
package iidl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int OP_W         = 3;
  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int STAT_W       = 2;
  localparam int CNT_OUT_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_EDIT   = 3'd3,
    OP_DELETE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADINDEX = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic wr;          // load value at target index
    logic shift_up;    // cells above target take left neighbor
    logic shift_down;  // cells at/above target take right neighbor
  } cell_cmd_t;

endpackage

// ===== rtl/core/iidl_cell.sv =====
// ----------------------------------------------------------------------------
// iidl_cell
// One list entry: holds a word, shifts from either neighbor or loads the
// broadcast value, and taps its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module iidl_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic                      clk,
  input  iidl_pkg::cell_cmd_t       cmd,
  input  logic [IW-1:0]             tgt,
  input  logic [IW-1:0]             pos,
  input  logic [iidl_pkg::VAL_W-1:0] wr_data,
  input  logic [iidl_pkg::VAL_W-1:0] prev_data,
  input  logic [iidl_pkg::VAL_W-1:0] next_data,
  output logic [iidl_pkg::VAL_W-1:0] data,
  output logic [iidl_pkg::VAL_W-1:0] rd_tap
);
  import iidl_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VAL_W-1:0] word;

  always_ff @(posedge clk) begin
    if (cmd.shift_up && (MY_IDX > tgt)) begin
      word <= prev_data;
    end else if (cmd.shift_down && (MY_IDX >= tgt)) begin
      word <= next_data;
    end else if (cmd.wr && (MY_IDX == tgt)) begin
      word <= wr_data;
    end
  end

  assign data   = word;
  assign rd_tap = (MY_IDX == pos) ? word : '0;

endmodule

// ===== rtl/core/indexed_insert_delete_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_unit
// Fixed-capacity ordered list of 32-bit words held in a chain of shift cells:
// append, insert, read, edit and delete, one result per transaction.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | operation, position, value
//   out     | out_valid / out_ready| status, read_value, element_count
//
// Every operation finishes in the cycle it is accepted; all cells shift in
// parallel, so the rate is one transaction per cycle while out_ready does not stall the output.
// The result sits in an output register in the cycle after acceptance; a new
// transaction is taken while that register is empty or being drained.
// Reset clears the element count and the output valid; words need no reset.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_unit #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iidl_pkg::OP_W-1:0]           operation,
  input  logic [iidl_pkg::POS_W-1:0]          position,
  input  logic signed [iidl_pkg::VAL_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [iidl_pkg::STAT_W-1:0]         status,
  output logic signed [iidl_pkg::VAL_W-1:0]   read_value,
  output logic [iidl_pkg::CNT_OUT_W-1:0]      element_count
);
  import iidl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             outv;
  status_t          stat;
  status_t          stat_next;
  logic [VAL_W-1:0] rd_q;
  logic [VAL_W-1:0] rd_next;
  logic [CNT_OUT_W-1:0] ecnt;

  logic             accept;
  logic             full;
  logic [IW-1:0]    pos_x;
  logic [IW-1:0]    cnt_x;
  logic [IW-1:0]    tgt;
  logic [IW-1:0]    cnt_next_x;
  cell_cmd_t        cmd;
  cell_cmd_t        cmd_dec;
  logic [VAL_W-1:0] rd_bus;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  logic [VAL_W-1:0] cell_tap  [CAPACITY];

  assign in_ready = !rst && (!outv || out_ready);
  assign accept   = in_valid && in_ready;
  assign pos_x    = IW'(position);
  assign cnt_x    = IW'(cnt);
  assign full     = (cnt == CNT_W'(CAPACITY));

  // read bus: at most one cell is addressed
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_tap[i];
    end
  end

  // operation decode
  always_comb begin
    stat_next = ST_OK;
    rd_next   = '0;
    cnt_next  = cnt;
    tgt       = pos_x;
    cmd_dec   = '0;
    unique case (operation)
      OP_APPEND: begin
        tgt = cnt_x;
        if (full) begin
          stat_next = ST_FULL;
        end else begin
          cmd_dec.wr = 1'b1;
          cnt_next   = cnt + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          stat_next = ST_BADINDEX;
        end else if (full) begin
          stat_next = ST_FULL;
        end else begin
          cmd_dec.wr       = 1'b1;
          cmd_dec.shift_up = 1'b1;
          cnt_next         = cnt + 1'b1;
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          stat_next = ST_BADINDEX;
          rd_next   = '1;
        end else begin
          rd_next = rd_bus;
        end
      end
      OP_EDIT: begin
        if (pos_x >= cnt_x) begin
          stat_next = ST_BADINDEX;
        end else begin
          cmd_dec.wr = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          stat_next = ST_BADINDEX;
        end else begin
          cmd_dec.shift_down = 1'b1;
          cnt_next           = cnt - 1'b1;
        end
      end
      default: begin
        stat_next = ST_BADINDEX;
      end
    endcase
  end

  assign cmd        = accept ? cmd_dec : '0;
  assign cnt_next_x = IW'(cnt_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      outv <= 1'b0;
    end else begin
      if (accept) begin
        cnt  <= cnt_next;
        outv <= 1'b1;
      end else if (out_ready) begin
        outv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
      rd_q <= rd_next;
      ecnt <= cnt_next_x[CNT_OUT_W-1:0];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] prev_d;
    logic [VAL_W-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = '0;
    end else begin : g_prev
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_next
      assign next_d = cell_data[g+1];
    end
    iidl_cell #(
      .IDX (g),
      .IW  (IW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .tgt       (tgt),
      .pos       (pos_x),
      .wr_data   (value),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[g]),
      .rd_tap    (cell_tap[g])
    );
  end

  assign out_valid     = outv;
  assign status        = stat;
  assign read_value    = rd_q;
  assign element_count = ecnt;

endmodule

// ===== rtl/core/iidl_checker.sv =====
// ----------------------------------------------------------------------------
// iidl_checker
// Port-level checks on the list unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_insert_delete_list_unit_defines.svh"

module iidl_checker #(
  parameter int CAPACITY = iidl_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [iidl_pkg::STAT_W-1:0]        status,
  input logic signed [iidl_pkg::VAL_W-1:0]  read_value,
  input logic [iidl_pkg::CNT_OUT_W-1:0]     element_count
);
  import iidl_pkg::*;

  localparam logic [CNT_OUT_W-1:0] CAP_OUT = CNT_OUT_W'(CAPACITY);

  logic [STAT_W+VAL_W+CNT_OUT_W-1:0] out_pl;

  assign out_pl = {status, read_value, element_count};

  // stalled result holds
  `IIDL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_pl))

  // every accepted transaction shows its result the next cycle
  `IIDL_ASSERT_NEXT(a_result_latency, clk, rst, in_valid && in_ready, out_valid)

  // full status only when the list holds capacity entries
  `IIDL_ASSERT_SAME(a_full_count, clk, rst, out_valid && status == ST_FULL, element_count == CAP_OUT)

  // a failed operation returns either zero or the invalid-read marker
  `IIDL_ASSERT_SAME(a_bad_value, clk, rst, out_valid && status != ST_OK, ~|read_value || &read_value)

endmodule

bind indexed_insert_delete_list_unit iidl_checker #(.CAPACITY(CAPACITY)) u_iidl_checker (.*);
